/* hdl/bda_pkg.sv */
package bda_pkg;

    localparam int unsigned BUTTON_W   = 3;
    localparam int unsigned DEBOUNCE_W = 8;
    localparam int unsigned HOLD_W     = 16;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned S_TDATA_W  = 8;
    localparam int unsigned M_TDATA_W  = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE_TICKS      = 2'd0,
        REG_REPEAT_DELAY_TICKS  = 2'd1,
        REG_REPEAT_PERIOD_TICKS = 2'd2
    } bda_reg_idx_t;

    typedef enum logic {
        FUNC_TICK = 1'b0,
        FUNC_TAKE = 1'b1
    } bda_func_t;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 8'd3;
    localparam logic [HOLD_W-1:0]     DELAY_RESET    = 16'd64;
    localparam logic [HOLD_W-1:0]     PERIOD_RESET   = 16'd16;

    typedef struct packed {
        logic [DEBOUNCE_W-1:0] debounce_ticks;
        logic [HOLD_W-1:0]     repeat_delay_ticks;
        logic [HOLD_W-1:0]     repeat_period_ticks;
    } bda_cfg_t;

    typedef struct packed {
        logic                repeat_active;
        logic [BUTTON_W-1:0] stable_buttons;
        logic [BUTTON_W-1:0] taken_buttons;
    } bda_result_t;

endpackage

/* hdl/bda_cfg.sv */
module bda_cfg
    import bda_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output bda_cfg_t              cfg
);

    bda_cfg_t cfg_reg;
    bda_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_DEBOUNCE_TICKS: begin
                    cfg_next.debounce_ticks = cfg_wdata[DEBOUNCE_W-1:0];
                end
                REG_REPEAT_DELAY_TICKS: begin
                    cfg_next.repeat_delay_ticks = cfg_wdata[HOLD_W-1:0];
                end
                REG_REPEAT_PERIOD_TICKS: begin
                    cfg_next.repeat_period_ticks = cfg_wdata[HOLD_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks      <= DEBOUNCE_RESET;
            cfg_reg.repeat_delay_ticks  <= DELAY_RESET;
            cfg_reg.repeat_period_ticks <= PERIOD_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/bda_engine.sv */
module bda_engine
    import bda_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  bda_cfg_t            cfg,
    input  logic                fire,
    input  bda_func_t           func,
    input  logic [BUTTON_W-1:0] pin_levels,
    output bda_result_t         result
);

    logic [BUTTON_W-1:0]   raw_reg,       raw_next;
    logic [BUTTON_W-1:0]   stable_reg,    stable_next;
    logic                  processed_reg, processed_next;
    logic                  repeating_reg, repeating_next;
    logic [DEBOUNCE_W-1:0] settle_reg,    settle_next;
    logic [HOLD_W-1:0]     hold_reg,      hold_next;

    logic [BUTTON_W-1:0]   sensed;
    logic [DEBOUNCE_W-1:0] settle_inc;
    logic [HOLD_W-1:0]     hold_inc;
    logic [BUTTON_W-1:0]   taken;

    always_comb begin
        sensed         = ~pin_levels;
        raw_next       = raw_reg;
        stable_next    = stable_reg;
        processed_next = processed_reg;
        repeating_next = repeating_reg;
        settle_next    = settle_reg;
        hold_next      = hold_reg;
        taken          = '0;
        settle_inc     = settle_reg + 1'b1;
        hold_inc       = '0;

        if (func == FUNC_TICK) begin
            if ((stable_reg != sensed) && (raw_reg == sensed)) begin
                settle_next = settle_inc;
                if (settle_inc >= cfg.debounce_ticks) begin
                    stable_next    = sensed;
                    processed_next = 1'b0;
                    repeating_next = 1'b0;
                    hold_next      = '0;
                end
            end else begin
                raw_next    = sensed;
                settle_next = '0;
            end

            if (stable_next != '0) begin
                hold_inc  = hold_next + 1'b1;
                hold_next = hold_inc;
                if (repeating_next) begin
                    if (hold_inc >= cfg.repeat_period_ticks) begin
                        processed_next = 1'b0;
                        hold_next      = '0;
                    end
                end else if (hold_inc >= cfg.repeat_delay_ticks) begin
                    repeating_next = 1'b1;
                end
            end
        end else begin
            if (!processed_reg && (stable_reg != '0)) begin
                processed_next = 1'b1;
                taken          = stable_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_reg       <= '0;
            stable_reg    <= '0;
            processed_reg <= 1'b0;
            repeating_reg <= 1'b0;
            settle_reg    <= '0;
            hold_reg      <= '0;
        end else if (fire) begin
            raw_reg       <= raw_next;
            stable_reg    <= stable_next;
            processed_reg <= processed_next;
            repeating_reg <= repeating_next;
            settle_reg    <= settle_next;
            hold_reg      <= hold_next;
        end
    end

    assign result.taken_buttons  = taken;
    assign result.stable_buttons = stable_next;
    assign result.repeat_active  = repeating_next;

    a_take_marks_processed: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (func == FUNC_TAKE) && (taken != '0) |=> processed_reg)
        else $error("A press was returned without being marked processed.");

    a_take_keeps_timing: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (func == FUNC_TAKE) |=> $stable(stable_reg) && $stable(hold_reg)
            && $stable(repeating_reg))
        else $error("A take transaction altered the debounce or hold timing.");

    a_no_repeat_when_released: assert property (@(posedge aclk) disable iff (!aresetn)
        stable_reg == '0 |-> !repeating_reg)
        else $error("Repeating is active with no button held.");

endmodule

/* hdl/button_debounce_autorepeat_top.sv */
// Debouncer with press-and-hold auto-repeat for three active-low buttons. Each input
// transaction is either a sampling tick (tuser low, pin levels in tdata) or a take
// (tuser high), and each gives exactly one result transaction carrying the press taken,
// the debounced button set and the repeat flag. One transaction is accepted every clock
// cycle unless the output stalls; its result passes through the input register and the
// result register, and the button state is updated as a transaction leaves the input
// register. Write the configuration registers only while no transaction is in flight.
module button_debounce_autorepeat_top
    import bda_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [2:0] pin_levels, rest zero
    input  logic                  s_tuser,   // [0] func
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [2:0] taken_buttons, [5:3] stable_buttons,
                                             // [6] repeat_active, [7] zero
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    bda_cfg_t    cfg;
    bda_result_t result;

    logic                in_valid_reg;
    logic                in_valid_next;
    bda_func_t           in_func_reg;
    logic [BUTTON_W-1:0] in_pins_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    bda_result_t         out_data_reg;
    logic                advance;

    assign advance        = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready       = !in_valid_reg || advance;
    assign in_valid_next  = s_tvalid || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= in_valid_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_func_reg <= bda_func_t'(s_tuser);
            in_pins_reg <= s_tdata[BUTTON_W-1:0];
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

    bda_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bda_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .fire       (advance),
        .func       (in_func_reg),
        .pin_levels (in_pins_reg),
        .result     (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_data_reg};

    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("A stalled transaction was dropped from the input register.");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("A processed transaction produced no result.");

endmodule

/* tb/button_debounce_autorepeat_top_test.sv */
`timescale 1ns / 100ps

module button_debounce_autorepeat_top_test;
    import bda_pkg::*;

    typedef struct packed {
        bda_func_t           op;
        logic [BUTTON_W-1:0] pins;
    } button_item_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    button_item_t pending_items[$];
    bda_result_t  expected_results[$];
    int unsigned  send_idle_pct = 0;
    int unsigned  recv_idle_pct = 0;
    int unsigned  mismatch_count = 0;

    logic [DEBOUNCE_W-1:0] cfg_debounce = DEBOUNCE_RESET;
    logic [HOLD_W-1:0]     cfg_delay    = DELAY_RESET;
    logic [HOLD_W-1:0]     cfg_period   = PERIOD_RESET;

    logic [BUTTON_W-1:0]   raw_seen     = '0;
    logic [BUTTON_W-1:0]   stable_held  = '0;
    logic                  press_taken  = 1'b0;
    logic                  repeating    = 1'b0;
    logic [DEBOUNCE_W-1:0] settle_cnt   = '0;
    logic [HOLD_W-1:0]     hold_cnt     = '0;

    button_debounce_autorepeat_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic bda_result_t debounce_step(bda_func_t op, logic [BUTTON_W-1:0] pins);
        bda_result_t         res;
        logic [BUTTON_W-1:0] sensed;
        res = '0;
        if (op == FUNC_TICK) begin
            sensed = ~pins;
            if (stable_held != sensed && raw_seen == sensed) begin
                settle_cnt = settle_cnt + 1'b1;
                if (settle_cnt >= cfg_debounce) begin
                    stable_held = sensed;
                    press_taken = 1'b0;
                    repeating   = 1'b0;
                    hold_cnt    = '0;
                end
            end else begin
                raw_seen   = sensed;
                settle_cnt = '0;
            end
            if (stable_held != '0) begin
                hold_cnt = hold_cnt + 1'b1;
                if (repeating) begin
                    if (hold_cnt >= cfg_period) begin
                        press_taken = 1'b0;
                        hold_cnt    = '0;
                    end
                end else if (hold_cnt >= cfg_delay) begin
                    repeating = 1'b1;
                end
            end
        end else if (!press_taken && stable_held != '0) begin
            press_taken       = 1'b1;
            res.taken_buttons = stable_held;
        end
        res.stable_buttons = stable_held;
        res.repeat_active  = repeating;
        return res;
    endfunction

    always @(posedge aclk) begin
        button_item_t item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(
                    debounce_step(bda_func_t'(s_tuser), s_tdata[BUTTON_W-1:0]));
            end
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= item.op;
                    s_tdata  <= {{(S_TDATA_W-BUTTON_W){1'b0}}, item.pins};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        bda_result_t got;
        bda_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = bda_result_t'(m_tdata[$bits(bda_result_t)-1:0]);
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Unexpected result: taken %0d stable %0d repeat %0d",
                                 got.taken_buttons, got.stable_buttons, got.repeat_active);
                end else begin
                    want = expected_results.pop_front();
                    if (got.taken_buttons !== want.taken_buttons
                        || got.stable_buttons !== want.stable_buttons
                        || got.repeat_active !== want.repeat_active) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $write("Mismatch: expected taken %0d stable %0d repeat %0d, ",
                                   want.taken_buttons, want.stable_buttons,
                                   want.repeat_active);
                            $display("got taken %0d stable %0d repeat %0d",
                                     got.taken_buttons, got.stable_buttons,
                                     got.repeat_active);
                        end
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic push_tick(logic [BUTTON_W-1:0] pins);
        button_item_t item;
        item.op   = FUNC_TICK;
        item.pins = pins;
        pending_items.push_back(item);
    endtask

    task automatic push_take();
        button_item_t item;
        item.op   = FUNC_TAKE;
        item.pins = BUTTON_W'($urandom_range(0, 7));
        pending_items.push_back(item);
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_setting(bda_reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_DEBOUNCE_TICKS:      cfg_debounce = value[DEBOUNCE_W-1:0];
            REG_REPEAT_DELAY_TICKS:  cfg_delay    = value[HOLD_W-1:0];
            REG_REPEAT_PERIOD_TICKS: cfg_period   = value[HOLD_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic apply_settings(int unsigned deb, int unsigned dly, int unsigned per);
        write_setting(REG_DEBOUNCE_TICKS, CFG_DATA_W'(deb));
        write_setting(REG_REPEAT_DELAY_TICKS, CFG_DATA_W'(dly));
        write_setting(REG_REPEAT_PERIOD_TICKS, CFG_DATA_W'(per));
    endtask

    // Mostly held button patterns long enough to settle and sometimes to repeat, with takes
    // scattered through them; the rest is bouncing pins and stray takes.
    task automatic queue_random(int unsigned budget);
        int unsigned         produced;
        int unsigned         span;
        int unsigned         reach;
        int unsigned         take_pct;
        logic [BUTTON_W-1:0] pins;
        produced = 0;
        while (produced < budget) begin
            if ($urandom_range(0, 99) < 80) begin
                pins     = BUTTON_W'($urandom_range(0, 7));
                reach    = int'(cfg_delay) + 4 * int'(cfg_period);
                if (reach > 100)
                    reach = 100;
                span     = int'(cfg_debounce) + 1 + $urandom_range(0, reach);
                take_pct = $urandom_range(5, 40);
                repeat (span) begin
                    if (produced >= budget)
                        break;
                    push_tick(pins);
                    produced++;
                    if ($urandom_range(0, 99) < take_pct) begin
                        push_take();
                        produced++;
                    end
                end
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    if ($urandom_range(0, 1) == 0)
                        push_tick(BUTTON_W'($urandom_range(0, 7)));
                    else
                        push_take();
                    produced++;
                end
            end
        end
    endtask

    task automatic run_phase(int unsigned budget);
        queue_random(budget / 2);
        wait_drained();
        queue_random(budget - budget / 2);
        wait_drained();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 23;
        recv_idle_pct = 56;
        push_take();
        push_tick(3'b111);
        repeat (4) push_tick(3'b110);
        push_take();
        push_take();
        push_tick(3'b110);
        push_tick(3'b011);
        push_tick(3'b110);
        wait_drained();
        run_phase(200);

        apply_settings(1, 1, 1);
        repeat (2) push_tick(3'b000);
        push_take();
        push_tick(3'b000);
        push_take();
        push_take();
        repeat (2) push_tick(3'b010);
        push_take();
        repeat (2) push_tick(3'b111);
        push_take();
        push_tick(3'b101);
        wait_drained();
        run_phase(250);

        apply_settings(2, 5, 3);
        run_phase(250);

        send_idle_pct = 56;
        recv_idle_pct = 23;
        apply_settings(255, 65535, 65535);
        run_phase(450);

        apply_settings(4, 12, 2);
        run_phase(250);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_settings(1, 3, 1);
        run_phase(250);

        apply_settings(3, 64, 16);
        run_phase(250);

        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #600000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
